// File: sv/hcm_pkg.sv
package hcm_pkg;

  typedef logic [4:0]  letter_t;
  typedef logic [9:0]  prod_t;
  typedef logic [10:0] wide_t;
  typedef logic [1:0]  cfg_idx_t;

  localparam letter_t MODULUS    = 5'd26;
  localparam letter_t PAD_LETTER = 5'd23;

  // Register indexes on the configuration port
  localparam cfg_idx_t CFG_KEY_TOP_LEFT     = 2'd0;
  localparam cfg_idx_t CFG_KEY_TOP_RIGHT    = 2'd1;
  localparam cfg_idx_t CFG_KEY_BOTTOM_LEFT  = 2'd2;
  localparam cfg_idx_t CFG_KEY_BOTTOM_RIGHT = 2'd3;

  localparam letter_t KEY_TOP_LEFT_RST     = 5'd9;
  localparam letter_t KEY_TOP_RIGHT_RST    = 5'd4;
  localparam letter_t KEY_BOTTOM_LEFT_RST  = 5'd5;
  localparam letter_t KEY_BOTTOM_RIGHT_RST = 5'd7;

  typedef struct packed {
    letter_t tl;
    letter_t tr;
    letter_t bl;
    letter_t br;
  } key_t;

  typedef struct packed {
    logic    func;
    letter_t p0;
    letter_t p1;
    logic    last;
  } blk_t;

  // Fold a 5-bit value into 0..25
  function automatic letter_t red26(letter_t v);
    return (v >= MODULUS) ? letter_t'(v - MODULUS) : v;
  endfunction

  // x mod 26 for x below 2048: floor(x/26) = (x * 2521) >> 16 is exact here
  function automatic letter_t mod26(wide_t x);
    logic [22:0] prod;
    logic [6:0]  q;
    wide_t       r;
    prod = 23'(x) * 23'(12'd2521);
    q    = 7'(prod >> 16);
    r    = x - 11'(q) * 11'(MODULUS);
    return r[4:0];
  endfunction

  // Multiplicative inverse modulo 26, zero where none exists
  function automatic letter_t inv26(letter_t v);
    letter_t r;
    case (v)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/hcm_if.sv
interface hcm_in_if;
  logic                 valid;
  logic                 ready;
  logic                 func;
  hcm_pkg::letter_t     letter;
  logic                 final_letter;

  modport source (output valid, func, letter, final_letter, input ready);
  modport sink   (input valid, func, letter, final_letter, output ready);
endinterface

interface hcm_out_if;
  logic                 valid;
  logic                 ready;
  hcm_pkg::letter_t     out_letter;
  logic                 out_last;
  logic                 key_error;

  modport source (output valid, out_letter, out_last, key_error, input ready);
  modport sink   (input valid, out_letter, out_last, key_error, output ready);
endinterface

// File: sv/hcm_front.sv
module hcm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  hcm_in_if.sink             in_i,
  input  logic               full_i,
  output logic               push_o,
  output hcm_pkg::blk_t      blk_o
);

  logic             half_q, half_d;
  hcm_pkg::letter_t held_q, held_d;
  hcm_pkg::letter_t letter;
  logic             accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign letter     = hcm_pkg::red26(in_i.letter);

  always_comb begin
    half_d      = half_q;
    held_d      = held_q;
    push_o      = 1'b0;
    blk_o.func  = in_i.func;
    blk_o.last  = in_i.final_letter;
    blk_o.p0    = half_q ? held_q : letter;
    blk_o.p1    = half_q ? letter : hcm_pkg::PAD_LETTER;
    if (accept) begin
      if (!half_q && !in_i.final_letter) begin
        // open a block: hold the first letter
        half_d = 1'b1;
        held_d = letter;
      end else begin
        half_d = 1'b0;
        push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= 1'b0;
    end else begin
      half_q <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

// File: sv/hcm_queue.sv
module hcm_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hcm_pkg::blk_t blk_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output hcm_pkg::blk_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hcm_pkg::blk_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= blk_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !do_pop |=> cnt_q == CntW'(Depth))
    else $error("queue count moved while full and not popped");

endmodule

// File: sv/hcm_back.sv
module hcm_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hcm_pkg::key_t key_i,
  input  logic          empty_i,
  input  hcm_pkg::blk_t head_i,
  output logic          pop_o,
  hcm_out_if.source     out_o
);

  logic                  adv;

  logic                  s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q;
  hcm_pkg::blk_t         s1_blk_q, s2_blk_q, s3_blk_q, s4_blk_q;
  hcm_pkg::prod_t        s1_ad_q, s1_bc_q;
  hcm_pkg::letter_t      s2_inv_q;
  hcm_pkg::prod_t        s3_m00_q, s3_m01_q, s3_m10_q, s3_m11_q;
  logic                  s3_err_q, s4_err_q, s5_err_q;
  hcm_pkg::letter_t      s4_m00_q, s4_m01_q, s4_m10_q, s4_m11_q;
  hcm_pkg::prod_t        s5_x00_q, s5_x01_q, s5_x10_q, s5_x11_q;
  logic                  s5_last_q;

  logic                  out_v_q, out_idx_q, out_last_q, out_err_q;
  hcm_pkg::letter_t      out_r0_q, out_r1_q;

  hcm_pkg::letter_t      neg_b, neg_c, det;

  // The output register holds a block for two transactions; advance the
  // whole pipe when it is empty or its second letter is taken.
  assign adv   = !out_v_q || (out_idx_q && out_o.ready);
  assign pop_o = adv && !empty_i;

  assign neg_b = (key_i.tr == '0) ? '0 : hcm_pkg::letter_t'(hcm_pkg::MODULUS - key_i.tr);
  assign neg_c = (key_i.bl == '0) ? '0 : hcm_pkg::letter_t'(hcm_pkg::MODULUS - key_i.bl);
  assign det   = hcm_pkg::mod26(hcm_pkg::wide_t'(s1_ad_q) + 11'd676
                                - hcm_pkg::wide_t'(s1_bc_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      s4_v_q    <= 1'b0;
      s5_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
      out_idx_q <= 1'b0;
    end else if (adv) begin
      s1_v_q    <= !empty_i;
      s2_v_q    <= s1_v_q;
      s3_v_q    <= s2_v_q;
      s4_v_q    <= s3_v_q;
      s5_v_q    <= s4_v_q;
      out_v_q   <= s5_v_q;
      out_idx_q <= 1'b0;
    end else if (out_v_q && out_o.ready) begin
      out_idx_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // determinant products
      s1_blk_q <= head_i;
      s1_ad_q  <= hcm_pkg::prod_t'(key_i.tl) * hcm_pkg::prod_t'(key_i.br);
      s1_bc_q  <= hcm_pkg::prod_t'(key_i.tr) * hcm_pkg::prod_t'(key_i.bl);
      // determinant inverse
      s2_blk_q <= s1_blk_q;
      s2_inv_q <= hcm_pkg::inv26(det);
      // matrix entries before reduction
      s3_blk_q <= s2_blk_q;
      s3_err_q <= s2_blk_q.func && (s2_inv_q == '0);
      if (s2_blk_q.func) begin
        s3_m00_q <= hcm_pkg::prod_t'(key_i.br) * hcm_pkg::prod_t'(s2_inv_q);
        s3_m01_q <= hcm_pkg::prod_t'(neg_b) * hcm_pkg::prod_t'(s2_inv_q);
        s3_m10_q <= hcm_pkg::prod_t'(neg_c) * hcm_pkg::prod_t'(s2_inv_q);
        s3_m11_q <= hcm_pkg::prod_t'(key_i.tl) * hcm_pkg::prod_t'(s2_inv_q);
      end else begin
        s3_m00_q <= hcm_pkg::prod_t'(key_i.tl);
        s3_m01_q <= hcm_pkg::prod_t'(key_i.tr);
        s3_m10_q <= hcm_pkg::prod_t'(key_i.bl);
        s3_m11_q <= hcm_pkg::prod_t'(key_i.br);
      end
      // reduce matrix
      s4_blk_q <= s3_blk_q;
      s4_err_q <= s3_err_q;
      s4_m00_q <= hcm_pkg::mod26(hcm_pkg::wide_t'(s3_m00_q));
      s4_m01_q <= hcm_pkg::mod26(hcm_pkg::wide_t'(s3_m01_q));
      s4_m10_q <= hcm_pkg::mod26(hcm_pkg::wide_t'(s3_m10_q));
      s4_m11_q <= hcm_pkg::mod26(hcm_pkg::wide_t'(s3_m11_q));
      // block products
      s5_err_q  <= s4_err_q;
      s5_last_q <= s4_blk_q.last;
      s5_x00_q  <= hcm_pkg::prod_t'(s4_m00_q) * hcm_pkg::prod_t'(s4_blk_q.p0);
      s5_x01_q  <= hcm_pkg::prod_t'(s4_m01_q) * hcm_pkg::prod_t'(s4_blk_q.p1);
      s5_x10_q  <= hcm_pkg::prod_t'(s4_m10_q) * hcm_pkg::prod_t'(s4_blk_q.p0);
      s5_x11_q  <= hcm_pkg::prod_t'(s4_m11_q) * hcm_pkg::prod_t'(s4_blk_q.p1);
      // sums and final reduction
      out_err_q  <= s5_err_q;
      out_last_q <= s5_last_q;
      out_r0_q   <= s5_err_q ? '0 : hcm_pkg::mod26(hcm_pkg::wide_t'(s5_x00_q)
                                                   + hcm_pkg::wide_t'(s5_x01_q));
      out_r1_q   <= s5_err_q ? '0 : hcm_pkg::mod26(hcm_pkg::wide_t'(s5_x10_q)
                                                   + hcm_pkg::wide_t'(s5_x11_q));
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.out_letter = out_idx_q ? out_r1_q : out_r0_q;
  assign out_o.out_last   = out_idx_q && out_last_q;
  assign out_o.key_error  = out_err_q;

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_idx_q && out_o.ready |=> out_v_q && out_idx_q)
    else $error("second letter of a block did not follow the first");

  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> out_o.out_letter < hcm_pkg::MODULUS)
    else $error("result letter out of range");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_err_q |-> out_o.out_letter == '0)
    else $error("singular key result not zero");

  a_last_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_idx_q |-> !out_o.out_last)
    else $error("last mark on first letter of a block");

endmodule

// File: sv/hill_cipher_2x2_mod26_unit.sv
// 2x2 Hill cipher over the alphabet A..Z (indices 0..25).
//
// in_i carries one letter per transaction with func (0 encrypt with the key,
// 1 decrypt with its inverse mod 26) and final_letter. Letters pair into
// blocks; the func of the completing letter selects the operation. A message
// of odd length is padded with X. Each block gives two transactions on out_o;
// the second carries out_last when the block ends the message. A decrypt key
// whose determinant has no inverse mod 26 returns 0 letters with key_error.
//
// Throughput: one letter per cycle in while the queue is not full and one
// result per cycle out while out_o is ready, on even messages; the output
// register holds a block for two transactions. From the transaction that
// completes a block, its first result transaction passes through the queue
// and six back-end stages: determinant, inverse, matrix, reduction, products,
// sums. The key registers are written through cfg_we_i/cfg_index_i/cfg_data_i
// by the user only while no block is in flight; the unit does not enforce it.
// Reset clears the held half block, the queue and the back-end pipe, and
// loads the key 9 4 / 5 7. When out_o stalls the back end holds; the queue
// absorbs blocks until full, then in_i drops ready.
module hill_cipher_2x2_mod26_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  hcm_in_if.sink              in_i,
  hcm_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  hcm_pkg::cfg_idx_t   cfg_index_i,
  input  hcm_pkg::letter_t    cfg_data_i
);

  hcm_pkg::key_t    key_q;
  hcm_pkg::letter_t cfg_val;
  logic             push, full, pop, empty;
  hcm_pkg::blk_t    blk, head;

  // Store key entries already folded into 0..25
  assign cfg_val = hcm_pkg::red26(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q.tl <= hcm_pkg::KEY_TOP_LEFT_RST;
      key_q.tr <= hcm_pkg::KEY_TOP_RIGHT_RST;
      key_q.bl <= hcm_pkg::KEY_BOTTOM_LEFT_RST;
      key_q.br <= hcm_pkg::KEY_BOTTOM_RIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        hcm_pkg::CFG_KEY_TOP_LEFT:     key_q.tl <= cfg_val;
        hcm_pkg::CFG_KEY_TOP_RIGHT:    key_q.tr <= cfg_val;
        hcm_pkg::CFG_KEY_BOTTOM_LEFT:  key_q.bl <= cfg_val;
        hcm_pkg::CFG_KEY_BOTTOM_RIGHT: key_q.br <= cfg_val;
        default: ;
      endcase
    end
  end

  // Front: pair letters, pad odd endings
  hcm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .blk_o  (blk)
  );

  // Queue of complete blocks between front and back
  hcm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .blk_i   (blk),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  // Back: key inversion and block multiply, two results per block
  hcm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .key_i   (key_q),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// File: tb/hill_cipher_2x2_mod26_unit_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the 2x2 Hill cipher unit.
// Letters go in on in_i, one per transaction. The scoreboard pairs them into
// blocks the same way the unit should and queues the two letters it expects
// for each block. Results taken off out_o are compared in order. The key is
// only loaded while nothing is in flight.
module hill_cipher_2x2_mod26_unit_tb;

  localparam int ALPHABET     = 26;
  localparam int X_PAD        = 23;
  localparam int DRAIN_CYCLES = 16;       // time for the back end to empty, with margin
  localparam int PHASE_LETTERS = 150;
  localparam int RANDOM_PHASES = 8;
  localparam longint TIMEOUT_NS = 64'd8_000_000;

  typedef enum logic {
    ENCRYPT = 1'b0,
    DECRYPT = 1'b1
  } cipher_op_e;

  typedef struct packed {
    hcm_pkg::letter_t ltr;
    logic             last;
    logic             kerr;
  } cipher_out_t;

  // Inverse of the key determinant mod 26, or 0 when it has none
  function automatic int det_inverse(int a, int b, int c, int d);
    int det;
    det = (a * d + ALPHABET * ALPHABET - b * c) % ALPHABET;
    for (int i = 1; i < ALPHABET; i++) begin
      if ((det * i) % ALPHABET == 1) return i;
    end
    return 0;
  endfunction

  class cipher_scoreboard;
    hcm_pkg::letter_t key_reg[4];
    int               held;
    bit               half;
    cipher_out_t      expected_letters[$];
    int               errors;

    function new();
      key_reg[hcm_pkg::CFG_KEY_TOP_LEFT]     = hcm_pkg::KEY_TOP_LEFT_RST;
      key_reg[hcm_pkg::CFG_KEY_TOP_RIGHT]    = hcm_pkg::KEY_TOP_RIGHT_RST;
      key_reg[hcm_pkg::CFG_KEY_BOTTOM_LEFT]  = hcm_pkg::KEY_BOTTOM_LEFT_RST;
      key_reg[hcm_pkg::CFG_KEY_BOTTOM_RIGHT] = hcm_pkg::KEY_BOTTOM_RIGHT_RST;
      held   = 0;
      half   = 1'b0;
      errors = 0;
    endfunction

    function void set_key(hcm_pkg::cfg_idx_t idx, hcm_pkg::letter_t v);
      key_reg[idx] = v;
    endfunction

    function int pending();
      return expected_letters.size();
    endfunction

    // Accepted letter: hold it, or close the block and queue both results
    function void note_letter(cipher_op_e op, hcm_pkg::letter_t letter, logic fin);
      int a, b, c, d, p0, p1, inv, ltr;
      int m00, m01, m10, m11;
      cipher_out_t r0, r1;
      logic kerr;
      ltr = int'(letter) % ALPHABET;
      if (!half) begin
        if (!fin) begin
          held = ltr;
          half = 1'b1;
          return;
        end
        p0 = ltr;
        p1 = X_PAD;
      end else begin
        p0 = held;
        p1 = ltr;
      end
      half = 1'b0;
      held = 0;
      a = int'(key_reg[hcm_pkg::CFG_KEY_TOP_LEFT]) % ALPHABET;
      b = int'(key_reg[hcm_pkg::CFG_KEY_TOP_RIGHT]) % ALPHABET;
      c = int'(key_reg[hcm_pkg::CFG_KEY_BOTTOM_LEFT]) % ALPHABET;
      d = int'(key_reg[hcm_pkg::CFG_KEY_BOTTOM_RIGHT]) % ALPHABET;
      kerr = 1'b0;
      if (op == ENCRYPT) begin
        m00 = a; m01 = b; m10 = c; m11 = d;
      end else begin
        inv  = det_inverse(a, b, c, d);
        m00  = (d * inv) % ALPHABET;
        m01  = (((ALPHABET - b) % ALPHABET) * inv) % ALPHABET;
        m10  = (((ALPHABET - c) % ALPHABET) * inv) % ALPHABET;
        m11  = (a * inv) % ALPHABET;
        kerr = (inv == 0);
      end
      r0.ltr  = kerr ? '0 : hcm_pkg::letter_t'((m00 * p0 + m01 * p1) % ALPHABET);
      r0.last = 1'b0;
      r0.kerr = kerr;
      r1.ltr  = kerr ? '0 : hcm_pkg::letter_t'((m10 * p0 + m11 * p1) % ALPHABET);
      r1.last = fin;
      r1.kerr = kerr;
      expected_letters.push_back(r0);
      expected_letters.push_back(r1);
    endfunction

    function void check_result(hcm_pkg::letter_t ltr, logic last, logic kerr);
      cipher_out_t exp_res;
      if (expected_letters.size() == 0) begin
        $error("out_letter: expected nothing, actual %0d (last %0b key_error %0b)",
               ltr, last, kerr);
        errors++;
        return;
      end
      exp_res = expected_letters.pop_front();
      if (ltr !== exp_res.ltr) begin
        $error("out_letter: expected %0d, actual %0d", exp_res.ltr, ltr);
        errors++;
      end
      if (last !== exp_res.last) begin
        $error("out_last: expected %0b, actual %0b", exp_res.last, last);
        errors++;
      end
      if (kerr !== exp_res.kerr) begin
        $error("key_error: expected %0b, actual %0b", exp_res.kerr, kerr);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic              cfg_we_i;
  hcm_pkg::cfg_idx_t cfg_index_i;
  hcm_pkg::letter_t  cfg_data_i;

  hcm_in_if  in_if ();
  hcm_out_if out_if ();

  int sender_idle_pct;
  int recv_stall_pct;
  int letters_sent;

  cipher_scoreboard sb = new();

  hill_cipher_2x2_mod26_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Throttle the result side; a new ready decision every falling edge
  always @(negedge clk_i) begin
    out_if.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Watch both channels at the rising edge, before the unit's flops move
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        sb.note_letter(cipher_op_e'(in_if.func), in_if.letter, in_if.final_letter);
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.out_letter, out_if.out_last, out_if.key_error);
    end
  end

  // Drive one letter; enter and leave on a falling edge with valid still high
  task automatic send_letter(input cipher_op_e op, input hcm_pkg::letter_t ltr,
                             input logic fin);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        = 1'b1;
    in_if.func         = op;
    in_if.letter       = ltr;
    in_if.final_letter = fin;
    do @(posedge clk_i); while (!in_if.ready);
    letters_sent++;
    @(negedge clk_i);
  endtask

  // One message of 1..9 letters; mostly one operation, now and then mixed
  task automatic send_random_message();
    int len;
    bit mixed;
    cipher_op_e op;
    hcm_pkg::letter_t ltr;
    len   = $urandom_range(1, 9);
    mixed = ($urandom_range(4) == 0);
    op    = cipher_op_e'($urandom_range(1));
    for (int i = 0; i < len; i++) begin
      if (mixed) op = cipher_op_e'($urandom_range(1));
      // letters 26..31 show up about one time in ten
      ltr = ($urandom_range(9) == 0) ? hcm_pkg::letter_t'($urandom_range(26, 31))
                                     : hcm_pkg::letter_t'($urandom_range(0, 25));
      send_letter(op, ltr, i == len - 1);
    end
  endtask

  // Let every queued result come out, then give the back end time to empty
  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Write all four key entries on consecutive edges; call on a falling edge
  task automatic load_key(input hcm_pkg::letter_t tl, input hcm_pkg::letter_t tr,
                          input hcm_pkg::letter_t bl, input hcm_pkg::letter_t br);
    hcm_pkg::letter_t vals[4];
    hcm_pkg::cfg_idx_t idx[4];
    vals = '{tl, tr, bl, br};
    idx  = '{hcm_pkg::CFG_KEY_TOP_LEFT, hcm_pkg::CFG_KEY_TOP_RIGHT,
             hcm_pkg::CFG_KEY_BOTTOM_LEFT, hcm_pkg::CFG_KEY_BOTTOM_RIGHT};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    = 1'b1;
      cfg_index_i = idx[i];
      cfg_data_i  = vals[i];
      @(negedge clk_i);
      sb.set_key(idx[i], vals[i]);
    end
    cfg_we_i = 1'b0;
  endtask

  initial begin
    #TIMEOUT_NS;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    hcm_pkg::letter_t k[4];
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = hcm_pkg::CFG_KEY_TOP_LEFT;
    cfg_data_i         = '0;
    in_if.valid        = 1'b0;
    in_if.func         = ENCRYPT;
    in_if.letter       = '0;
    in_if.final_letter = 1'b0;
    sender_idle_pct    = 0;
    recv_stall_pct     = 0;
    letters_sent       = 0;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset key 9 4 / 5 7, invertible
    send_letter(ENCRYPT, 5'd0,  1'b0);
    send_letter(ENCRYPT, 5'd0,  1'b1);
    send_letter(ENCRYPT, 5'd25, 1'b0);
    send_letter(ENCRYPT, 5'd25, 1'b1);
    send_letter(DECRYPT, 5'd31, 1'b0);   // out-of-range letters fold mod 26
    send_letter(DECRYPT, 5'd26, 1'b1);
    send_letter(ENCRYPT, 5'd7,  1'b1);   // odd length, padded with X
    send_letter(DECRYPT, 5'd19, 1'b1);
    send_letter(DECRYPT, 5'd3,  1'b0);   // completing letter picks the operation
    send_letter(ENCRYPT, 5'd11, 1'b1);
    send_letter(ENCRYPT, 5'd1,  1'b0);   // block closes without ending the message
    send_letter(DECRYPT, 5'd2,  1'b0);
    send_letter(ENCRYPT, 5'd30, 1'b0);
    send_letter(DECRYPT, 5'd5,  1'b1);
    send_letter(ENCRYPT, 5'd28, 1'b1);
    wait_drained();

    // All entries 31: fold to 5, singular
    load_key(5'd31, 5'd31, 5'd31, 5'd31);
    send_letter(DECRYPT, 5'd4,  1'b0);
    send_letter(DECRYPT, 5'd9,  1'b1);
    send_letter(ENCRYPT, 5'd4,  1'b0);   // encrypt never flags the key
    send_letter(ENCRYPT, 5'd9,  1'b1);
    send_letter(DECRYPT, 5'd12, 1'b1);
    wait_drained();

    load_key(5'd0, 5'd0, 5'd0, 5'd0);
    send_letter(ENCRYPT, 5'd17, 1'b0);
    send_letter(ENCRYPT, 5'd22, 1'b1);
    send_letter(DECRYPT, 5'd17, 1'b1);
    wait_drained();

    // 25 26 / 27 25 folds to 25 0 / 1 25, determinant 1
    load_key(5'd25, 5'd26, 5'd27, 5'd25);
    send_letter(DECRYPT, 5'd8,  1'b0);
    send_letter(DECRYPT, 5'd14, 1'b1);
    send_letter(ENCRYPT, 5'd24, 1'b1);
    wait_drained();

    // Random traffic: each phase gets a fresh key and its own throttling
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin sender_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      // most phases want an invertible key so decrypt does real work
      do begin
        foreach (k[i]) k[i] = hcm_pkg::letter_t'($urandom_range(0, 31));
      end while (ph < RANDOM_PHASES - 2 &&
                 det_inverse(k[0] % ALPHABET, k[1] % ALPHABET,
                             k[2] % ALPHABET, k[3] % ALPHABET) == 0);
      load_key(k[0], k[1], k[2], k[3]);
      letters_sent = 0;
      while (letters_sent < PHASE_LETTERS) send_random_message();
      wait_drained();
    end

    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
sv/hcm_pkg.sv
sv/hcm_if.sv
sv/hcm_front.sv
sv/hcm_queue.sv
sv/hcm_back.sv
sv/hill_cipher_2x2_mod26_unit.sv
tb/hill_cipher_2x2_mod26_unit_tb.sv
